// ===== rtl/dhtm_pkg.sv =====
`timescale 1ns / 1ps

package dhtm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MARGIN_WIDTH = 15;
    localparam int COUNT_WIDTH  = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Comparisons are made one bit wider than the sample so that base plus or
    // minus margin never wraps.
    localparam int CMP_WIDTH = SAMPLE_WIDTH + 1;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD_BASE    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HYSTERESIS_MARGIN = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELAY_TICKS       = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] DELAY_RESET = COUNT_WIDTH'(1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] threshold_base;
        logic [MARGIN_WIDTH-1:0]        hysteresis_margin;
        logic [COUNT_WIDTH-1:0]         delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic                           func;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } item_t;

    typedef struct packed {
        logic state_active;
        logic state_changed;
        logic delay_armed;
        logic hysteresis_return;
    } result_t;

endpackage

// ===== rtl/dhtm_if.sv =====
`timescale 1ns / 1ps

interface dhtm_item_if
    import dhtm_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

interface dhtm_result_if;
    logic valid;
    logic ready;
    logic state_active;
    logic state_changed;
    logic delay_armed;
    logic hysteresis_return;

    modport source (output valid, output state_active, output state_changed,
                    output delay_armed, output hysteresis_return, input ready);
    modport sink   (input valid, input state_active, input state_changed,
                    input delay_armed, input hysteresis_return, output ready);
endinterface

// ===== rtl/dhtm_cfg_regs.sv =====
`timescale 1ns / 1ps

module dhtm_cfg_regs
    import dhtm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD_BASE:
                    cfg_next.threshold_base = signed'(cfg_data[SAMPLE_WIDTH-1:0]);
                REG_HYSTERESIS_MARGIN:
                    cfg_next.hysteresis_margin = cfg_data[MARGIN_WIDTH-1:0];
                REG_DELAY_TICKS:
                    cfg_next.delay_ticks = cfg_data[COUNT_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_base    <= '0;
            cfg_reg.hysteresis_margin <= '0;
            cfg_reg.delay_ticks       <= DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dhtm_in_stage.sv =====
`timescale 1ns / 1ps

module dhtm_in_stage
    import dhtm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dhtm_item_if.sink  item,
    input  logic       advance,
    output logic       stage_valid,
    output item_t      stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.func   <= item.func;
            item_reg.sample <= item.sample;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== rtl/dhtm_core.sv =====
`timescale 1ns / 1ps

module dhtm_core
    import dhtm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  item_t   stage_item,
    output result_t res
);

    logic                   active_reg,  active_next;
    logic                   pending_reg, pending_next;
    logic                   armed_reg,   armed_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                   mode_reg,    mode_next;
    logic                   changed;

    logic signed [CMP_WIDTH-1:0] base_ext;
    logic signed [CMP_WIDTH-1:0] margin_ext;
    logic signed [CMP_WIDTH-1:0] upper;
    logic signed [CMP_WIDTH-1:0] lower;
    logic signed [CMP_WIDTH-1:0] thr;
    logic signed [CMP_WIDTH-1:0] y_ext;
    logic [COUNT_WIDTH:0]        elapsed_inc;
    logic [COUNT_WIDTH-1:0]      limit;
    logic                        expire;

    assign base_ext    = CMP_WIDTH'(cfg.threshold_base);
    assign margin_ext  = signed'(CMP_WIDTH'(cfg.hysteresis_margin));
    assign upper       = base_ext + margin_ext;
    assign lower       = base_ext - margin_ext;
    assign thr         = mode_reg ? lower : base_ext;
    assign y_ext       = CMP_WIDTH'(stage_item.sample);
    assign elapsed_inc = {1'b0, elapsed_reg} + (COUNT_WIDTH+1)'(1);
    assign limit       = (cfg.delay_ticks == '0) ? COUNT_WIDTH'(1) : cfg.delay_ticks;
    assign expire      = elapsed_inc >= {1'b0, limit};

    always_comb
    begin
        active_next  = active_reg;
        pending_next = pending_reg;
        armed_next   = armed_reg;
        elapsed_next = elapsed_reg;
        mode_next    = mode_reg;
        changed      = 1'b0;
        case (stage_item.func)
            FUNC_TICK:
            begin
                if (armed_reg)
                begin
                    if (expire)
                    begin
                        active_next  = pending_reg;
                        changed      = 1'b1;
                        armed_next   = 1'b0;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc[COUNT_WIDTH-1:0];
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (!active_reg)
                begin
                    if (y_ext > upper && !armed_reg)
                    begin
                        armed_next   = 1'b1;
                        elapsed_next = '0;
                        pending_next = 1'b1;
                        mode_next    = 1'b0;
                    end
                    else if (y_ext > base_ext && !armed_reg)
                    begin
                        armed_next   = 1'b1;
                        elapsed_next = '0;
                        pending_next = 1'b1;
                        mode_next    = 1'b1;
                    end
                    else if (y_ext <= base_ext && armed_reg)
                    begin
                        armed_next   = 1'b0;
                        elapsed_next = '0;
                        pending_next = 1'b0;
                    end
                end
                else
                begin
                    if (y_ext <= thr && !armed_reg)
                    begin
                        armed_next   = 1'b1;
                        elapsed_next = '0;
                        pending_next = 1'b0;
                    end
                    else if (y_ext > thr && armed_reg)
                    begin
                        armed_next   = 1'b0;
                        elapsed_next = '0;
                        pending_next = 1'b1;
                    end
                end
            end
            default:
            begin
                changed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
            armed_reg   <= 1'b0;
            elapsed_reg <= '0;
            mode_reg    <= 1'b0;
        end
        else if (advance)
        begin
            active_reg  <= active_next;
            pending_reg <= pending_next;
            armed_reg   <= armed_next;
            elapsed_reg <= elapsed_next;
            mode_reg    <= mode_next;
        end
    end

    assign res.state_active      = active_next;
    assign res.state_changed     = changed;
    assign res.delay_armed       = armed_next;
    assign res.hysteresis_return = mode_next;

endmodule

// ===== rtl/dhtm_out_stage.sv =====
`timescale 1ns / 1ps

module dhtm_out_stage
    import dhtm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           stage_valid,
    input  result_t        res,
    output logic           advance,
    dhtm_result_if.source  result
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance = stage_valid && (!valid_reg || result.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid             = valid_reg;
    assign result.state_active      = res_reg.state_active;
    assign result.state_changed     = res_reg.state_changed;
    assign result.delay_armed       = res_reg.delay_armed;
    assign result.hysteresis_return = res_reg.hysteresis_return;

endmodule

// ===== rtl/delayed_hysteresis_threshold_monitor.sv =====
// Delayed threshold monitor with hysteresis.
// The item channel carries sample requests (func low) and timer tick requests
// (func high); the result channel returns one result for every request, in
// order, with the state after that request, whether a delayed change took
// effect on it, whether a change is pending and the current return mode.
// The configuration port writes the base threshold, the margin and the delay
// length in ticks; the user must write it only while no request is in flight,
// which the block itself does not enforce. A request is held in an input
// register, evaluated in one pass of compare and count logic and written into
// the result register, from which its result is offered to the receiver.
// One request is accepted in every cycle while the receiver takes results;
// the rate is set by the single state update per cycle.
// When the receiver stalls, the result register holds its value, the input
// register fills and then the item channel drops ready until the result is
// taken; nothing is lost or repeated.
// Reset puts the monitor in passive state with no change pending, plain
// return mode, base and margin zero and a delay of one tick.
`timescale 1ns / 1ps

module delayed_hysteresis_threshold_monitor
    import dhtm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    dhtm_item_if.sink                  item,
    dhtm_result_if.source              result,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    advance;
    logic    stage_valid;
    item_t   stage_item;
    result_t res;

    dhtm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhtm_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    dhtm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (advance),
        .stage_item (stage_item),
        .res        (res)
    );

    dhtm_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .res         (res),
        .advance     (advance),
        .result      (result)
    );

    // A delayed change always ends the pending period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.state_changed) |-> !result.delay_armed)
        else $error("state change reported while a change is still pending");

    // Sample requests never complete a delayed change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_item.func == FUNC_SAMPLE) |=> !result.state_changed)
        else $error("state change reported for a sample request");

    // The input register only moves on when the result register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (stage_valid && (!result.valid || result.ready)))
        else $error("request advanced into a full result register");

endmodule

// ===== tb/delayed_hysteresis_threshold_monitor_tb.sv =====
`timescale 1ns / 1ps

module delayed_hysteresis_threshold_monitor_tb;
    import dhtm_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 150;

    class monitor_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] base = '0;
        logic [MARGIN_WIDTH-1:0]        margin = '0;
        logic [COUNT_WIDTH-1:0]         delay = DELAY_RESET;
        logic                           active = 1'b0;
        logic                           pending = 1'b0;
        logic                           armed = 1'b0;
        logic                           mode = 1'b0;
        logic [COUNT_WIDTH-1:0]         elapsed = '0;
        result_t                        expected_states[$];
        int                             failures = 0;

        function void note_request(logic func, logic [SAMPLE_WIDTH-1:0] sample);
            int      b;
            int      m;
            int      y;
            int      thr;
            int      lim;
            int      nxt;
            logic    changed;
            result_t state;
            b = base;
            m = margin;
            y = $signed(sample);
            changed = 1'b0;
            if (func == FUNC_TICK) begin
                if (armed) begin
                    lim = (delay == 0) ? 1 : delay;
                    nxt = elapsed + 1;
                    if (nxt >= lim) begin
                        active = pending;
                        changed = 1'b1;
                        armed = 1'b0;
                        elapsed = '0;
                    end
                    else begin
                        elapsed = nxt[COUNT_WIDTH-1:0];
                    end
                end
            end
            else if (!active) begin
                if (y > b + m && !armed) begin
                    armed = 1'b1;
                    elapsed = '0;
                    pending = 1'b1;
                    mode = 1'b0;
                end
                else if (y > b && !armed) begin
                    armed = 1'b1;
                    elapsed = '0;
                    pending = 1'b1;
                    mode = 1'b1;
                end
                else if (y <= b && armed) begin
                    armed = 1'b0;
                    elapsed = '0;
                    pending = 1'b0;
                end
            end
            else begin
                thr = mode ? b - m : b;
                if (y <= thr && !armed) begin
                    armed = 1'b1;
                    elapsed = '0;
                    pending = 1'b0;
                end
                else if (y > thr && armed) begin
                    armed = 1'b0;
                    elapsed = '0;
                    pending = 1'b1;
                end
            end
            state.state_active = active;
            state.state_changed = changed;
            state.delay_armed = armed;
            state.hysteresis_return = mode;
            expected_states.push_back(state);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_states.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %b",
                         $time, got);
                failures++;
            end
            else begin
                want = expected_states.pop_front();
                compare_field("state_active", want.state_active, got.state_active);
                compare_field("state_changed", want.state_changed, got.state_changed);
                compare_field("delay_armed", want.delay_armed, got.delay_armed);
                compare_field("hysteresis_return", want.hysteresis_return,
                              got.hysteresis_return);
            end
        endfunction

        function int outstanding();
            return expected_states.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    dhtm_item_if   item_ch ();
    dhtm_result_if result_ch ();

    monitor_scoreboard sb = new();

    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int burst_left = 0;

    delayed_hysteresis_threshold_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic send_request(input logic func, input logic [SAMPLE_WIDTH-1:0] sample);
        if (!quiet && burst_left == 0 && $urandom_range(0, 99) < 26) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.func <= func;
        item_ch.sample <= sample;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_request(func, sample);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic put_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        case (index)
            REG_THRESHOLD_BASE:    sb.base = data;
            REG_HYSTERESIS_MARGIN: sb.margin = data[MARGIN_WIDTH-1:0];
            REG_DELAY_TICKS:       sb.delay = data;
            default:               ;
        endcase
    endtask

    task automatic load_config(input logic [CFG_DATA_WIDTH-1:0] base_v,
                               input logic [CFG_DATA_WIDTH-1:0] margin_v,
                               input logic [CFG_DATA_WIDTH-1:0] delay_v);
        wait_drained();
        repeat (4) @(posedge clk);
        put_register(REG_THRESHOLD_BASE, base_v);
        put_register(REG_HYSTERESIS_MARGIN, margin_v);
        put_register(REG_DELAY_TICKS, delay_v);
        put_register(REG_UNUSED, CFG_DATA_WIDTH'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Most samples land close to one of the thresholds so that arming and
    // cancelling happen often.
    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        int v;
        int b;
        int m;
        b = sb.base;
        m = sb.margin;
        case ($urandom_range(0, 4))
            0:       v = int'($urandom_range(0, 65535)) - 32768;
            1:       v = b + int'($urandom_range(0, 8)) - 4;
            2:       v = b + m + int'($urandom_range(0, 8)) - 4;
            3:       v = b - m + int'($urandom_range(0, 8)) - 4;
            default: v = b + int'($urandom_range(0, 2 * m + 16)) - m - 8;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    initial
    begin : receiver
        int hold_cycles;
        result_t got;
        hold_cycles = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready) begin
                got.state_active = result_ch.state_active;
                got.state_changed = result_ch.state_changed;
                got.delay_armed = result_ch.delay_armed;
                got.hysteresis_return = result_ch.hysteresis_return;
                sb.check_result(got);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_request) begin
                hold_request = 1'b0;
                hold_cycles = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= quiet || $urandom_range(0, 99) >= 26;
            end
        end
    end

    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic                    func;
        logic [SAMPLE_WIDTH-1:0] sample;
        logic [CFG_DATA_WIDTH-1:0] base_v;
        logic [CFG_DATA_WIDTH-1:0] margin_v;
        logic [CFG_DATA_WIDTH-1:0] delay_v;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.func <= FUNC_SAMPLE;
        item_ch.sample <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a tick while idle does nothing, a zero-margin rise and fall.
        send_request(FUNC_TICK, 16'h1234);
        send_request(FUNC_SAMPLE, 16'h0001);
        send_request(FUNC_TICK, 16'hFFFF);
        send_request(FUNC_SAMPLE, 16'h0000);
        send_request(FUNC_SAMPLE, 16'h0001);
        send_request(FUNC_SAMPLE, 16'h8000);
        send_request(FUNC_TICK, 16'h0000);

        // The return mode stays put while armed, then a hysteresis return.
        load_config(16'd100, 16'd50, 16'd3);
        send_request(FUNC_SAMPLE, 16'd200);
        send_request(FUNC_SAMPLE, 16'd120);
        send_request(FUNC_SAMPLE, 16'd100);
        send_request(FUNC_SAMPLE, 16'd120);
        send_request(FUNC_TICK, 16'h0000);
        send_request(FUNC_TICK, 16'h5555);
        send_request(FUNC_TICK, 16'hAAAA);
        send_request(FUNC_SAMPLE, 16'd60);
        send_request(FUNC_SAMPLE, 16'd50);
        send_request(FUNC_SAMPLE, 16'd51);
        send_request(FUNC_SAMPLE, 16'h7FFF);
        send_request(FUNC_SAMPLE, 16'h8000);
        send_request(FUNC_TICK, 16'h0000);
        send_request(FUNC_TICK, 16'h0000);
        send_request(FUNC_TICK, 16'h0000);

        // Extreme base and margin with a zero delay, which behaves as one tick.
        load_config(16'h8000, 16'hFFFF, 16'd0);
        send_request(FUNC_SAMPLE, 16'h0000);
        send_request(FUNC_TICK, 16'h0000);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    base_v = 16'h8000;
                    margin_v = 16'h7FFF;
                    delay_v = 16'd2;
                end
                1:
                begin
                    base_v = 16'h7FFF;
                    margin_v = 16'h0000;
                    delay_v = 16'd1;
                end
                2:
                begin
                    base_v = CFG_DATA_WIDTH'($urandom);
                    margin_v = CFG_DATA_WIDTH'($urandom_range(0, 200));
                    delay_v = 16'd0;
                end
                5:
                begin
                    base_v = CFG_DATA_WIDTH'($urandom);
                    margin_v = CFG_DATA_WIDTH'($urandom);
                    delay_v = 16'hFFFF;
                end
                default:
                begin
                    base_v = CFG_DATA_WIDTH'($urandom);
                    margin_v = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 300))};
                    delay_v = CFG_DATA_WIDTH'($urandom_range(1, 6));
                end
            endcase
            load_config(base_v, margin_v, delay_v);
            quiet = (phase == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // The receiver stalls for a long stretch while requests keep coming.
                if (phase == 2 && i == 20) begin
                    hold_request = 1'b1;
                    burst_left = 40;
                end
                func = ($urandom_range(0, 99) < 40) ? FUNC_TICK : FUNC_SAMPLE;
                sample = (func == FUNC_TICK) ? SAMPLE_WIDTH'($urandom) : pick_sample();
                send_request(func, sample);
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.outstanding() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, sb.outstanding());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
